// ----- rtl/core/gfsh_pkg.sv -----
`default_nettype none

package gfsh_pkg;

    localparam int TYPE_W      = 8;
    localparam int STD_W       = 16;
    localparam int SUM_W       = STD_W + 1;
    localparam int CNT_W       = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TYPE_W-1:0] RTK_FIXED_CODE = 8'd4;
    localparam logic [CNT_W-1:0]  CNT_MAX        = 8'd255;

    localparam logic [STD_W-1:0] STD_THRESHOLD_RESET = 16'd100;
    localparam logic [CNT_W-1:0] CONFIRM_RESET       = 8'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_STD_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM       = 8'd1;

    typedef struct packed {
        logic             stable;
        logic             pend_val;
        logic [CNT_W-1:0] pend_cnt;
    } gfsh_deb_t;

endpackage

`default_nettype wire

// ----- rtl/core/gfsh_sol_if.sv -----
`default_nettype none

interface gfsh_sol_if
    import gfsh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] pos_type;
    logic [STD_W-1:0]  lat_std_mm;
    logic [STD_W-1:0]  lon_std_mm;

    modport source (output valid, output pos_type, output lat_std_mm,
                    output lon_std_mm, input ready);
    modport sink   (input valid, input pos_type, input lat_std_mm,
                    input lon_std_mm, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gfsh_res_if.sv -----
`default_nettype none

interface gfsh_res_if;
    logic valid;
    logic ready;
    logic rtk_fixed_stable;
    logic std_converged_stable;
    logic rtk_changed;
    logic std_changed;

    modport source (output valid, output rtk_fixed_stable, output std_converged_stable,
                    output rtk_changed, output std_changed, input ready);
    modport sink   (input valid, input rtk_fixed_stable, input std_converged_stable,
                    input rtk_changed, input std_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gfsh_cfg_if.sv -----
`default_nettype none

interface gfsh_cfg_if
    import gfsh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gnss_fix_status_hysteresis_top.sv -----
// gnss fix status debouncer
// sol: one gnss solution per item (position type, lat/lon std deviation in mm)
// res: one result per solution item: the qualified rtk fixed and converged
//      flags plus one-item change pulses for each
// cfg: register writes, index 0 is the std threshold (mm), index 1 the
//      confirm count; always ready, write only while the block is idle
// an item taken lands in the input register, is evaluated combinationally
// and written into the result register once that register is free, and
// is presented on res from there; one item per cycle is sustained as
// long as the receiver takes results every cycle
// when the receiver stalls the result register holds, an empty input
// register takes one more item, then sol.ready drops until res moves again
// reset clears the debouncer state, both valids and restores the register
// defaults (threshold 100, confirm 5); the first item after reset seeds the
// stable flags with no change pulse
`default_nettype none

module gnss_fix_status_hysteresis_top
    import gfsh_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    gfsh_sol_if.sink    sol,
    gfsh_res_if.source  res,
    gfsh_cfg_if.sink    cfg
);

    logic [STD_W-1:0]  threshold_reg;
    logic [CNT_W-1:0]  confirm_reg;

    logic              s1_valid_reg;
    logic [TYPE_W-1:0] s1_type_reg;
    logic [STD_W-1:0]  s1_lat_reg;
    logic [STD_W-1:0]  s1_lon_reg;

    logic              seeded_reg;
    gfsh_deb_t         rtk_reg, rtk_next;
    gfsh_deb_t         conv_reg, conv_next;

    logic              out_valid_reg;
    logic              out_rtk_reg;
    logic              out_conv_reg;
    logic              out_rtk_chg_reg;
    logic              out_conv_chg_reg;

    logic              rtk_chg, conv_chg;
    logic              raw_rtk, raw_conv;
    logic [SUM_W-1:0]  std_sum, thr_x2;
    logic              advance;
    logic              take_in;

    function automatic gfsh_deb_t deb_step(input logic raw, input gfsh_deb_t cur,
                                           input logic [CNT_W-1:0] confirm,
                                           output logic chg);
        gfsh_deb_t nx;
        nx  = cur;
        chg = 1'b0;
        if (raw == cur.stable) begin
            nx.pend_cnt = '0;
        end
        else begin
            if (cur.pend_cnt == '0 || cur.pend_val != raw) begin
                nx.pend_val = raw;
                nx.pend_cnt = CNT_W'(1);
            end
            else if (cur.pend_cnt < CNT_MAX) begin
                nx.pend_cnt = cur.pend_cnt + CNT_W'(1);
            end
            if (nx.pend_cnt >= confirm) begin
                nx.stable   = raw;
                nx.pend_cnt = '0;
                chg         = 1'b1;
            end
        end
        return nx;
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= STD_THRESHOLD_RESET;
            confirm_reg   <= CONFIRM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STD_THRESHOLD: threshold_reg <= cfg.data;
                REG_CONFIRM:       confirm_reg   <= cfg.data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // result register frees up when empty or taken this cycle
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign sol.ready = !s1_valid_reg || advance;
    assign take_in   = sol.valid && sol.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_type_reg <= sol.pos_type;
            s1_lat_reg  <= sol.lat_std_mm;
            s1_lon_reg  <= sol.lon_std_mm;
        end
    end

    // mean <= threshold done as lat + lon <= 2 * threshold
    assign std_sum  = {1'b0, s1_lat_reg} + {1'b0, s1_lon_reg};
    assign thr_x2   = {threshold_reg, 1'b0};
    assign raw_rtk  = (s1_type_reg == RTK_FIXED_CODE);
    assign raw_conv = (std_sum <= thr_x2);

    always_comb
    begin
        rtk_chg  = 1'b0;
        conv_chg = 1'b0;
        rtk_next  = rtk_reg;
        conv_next = conv_reg;
        if (!seeded_reg)
        begin
            rtk_next.stable    = raw_rtk;
            rtk_next.pend_cnt  = '0;
            conv_next.stable   = raw_conv;
            conv_next.pend_cnt = '0;
        end
        else
        begin
            rtk_next  = deb_step(raw_rtk, rtk_reg, confirm_reg, rtk_chg);
            conv_next = deb_step(raw_conv, conv_reg, confirm_reg, conv_chg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            rtk_reg    <= '0;
            conv_reg   <= '0;
        end
        else if (advance)
        begin
            seeded_reg <= 1'b1;
            rtk_reg    <= rtk_next;
            conv_reg   <= conv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rtk_reg      <= rtk_next.stable;
            out_conv_reg     <= conv_next.stable;
            out_rtk_chg_reg  <= rtk_chg;
            out_conv_chg_reg <= conv_chg;
        end
    end

    assign res.valid                = out_valid_reg;
    assign res.rtk_fixed_stable     = out_rtk_reg;
    assign res.std_converged_stable = out_conv_reg;
    assign res.rtk_changed          = out_rtk_chg_reg;
    assign res.std_changed          = out_conv_chg_reg;

`ifndef NO_ASSERTIONS
    a_unseeded_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !seeded_reg |-> (rtk_reg.pend_cnt == '0 && conv_reg.pend_cnt == '0))
        else $error("pending count set before the seeding item");

    a_rtk_pulse_flips: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (!res.rtk_changed || res.rtk_fixed_stable != $past(rtk_reg.stable)))
        else $error("rtk change pulse without a flip of the stable flag");

    a_conv_pulse_flips: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (!res.std_changed || res.std_converged_stable != $past(conv_reg.stable)))
        else $error("converged change pulse without a flip of the stable flag");

    a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && !sol.ready == !advance))
        else $error("input register lost an item while the result was stalled");
`endif

endmodule

`default_nettype wire

// ----- bench/fix_status_checker.sv -----
`timescale 1ns / 100ps

module fix_status_checker
    import gfsh_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    gfsh_sol_if  sol,
    gfsh_res_if  res,
    gfsh_cfg_if  cfg,
    output int   outstanding,
    output int   fail_count
);

    typedef struct packed {
        logic rtk;
        logic conv;
        logic rtk_chg;
        logic conv_chg;
    } fix_status_t;

    logic [STD_W-1:0] thr_mm;
    logic [CNT_W-1:0] confirm;
    logic             seeded;
    gfsh_deb_t        rtk_deb;
    gfsh_deb_t        conv_deb;
    fix_status_t      status_q[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic note_error(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one debouncer step; the stable flag flips when the pending run is long enough
    function automatic gfsh_deb_t qualify(input gfsh_deb_t d, input logic raw,
                                          input logic [CNT_W-1:0] need);
        gfsh_deb_t n;
        n = d;
        if (raw == d.stable) begin
            n.pend_cnt = '0;
        end
        else begin
            if (d.pend_cnt == '0 || d.pend_val != raw) begin
                n.pend_val = raw;
                n.pend_cnt = CNT_W'(1);
            end
            else if (d.pend_cnt != CNT_MAX) begin
                n.pend_cnt = d.pend_cnt + CNT_W'(1);
            end
            if (n.pend_cnt >= need) begin
                n.stable   = raw;
                n.pend_cnt = '0;
            end
        end
        return n;
    endfunction

    task automatic predict_status(input logic [TYPE_W-1:0] ptype,
                                  input logic [STD_W-1:0] lat, input logic [STD_W-1:0] lon);
        logic             raw_rtk;
        logic             raw_conv;
        logic [SUM_W-1:0] sum;
        gfsh_deb_t        nr;
        gfsh_deb_t        nc;
        fix_status_t      e;
        raw_rtk  = (ptype == RTK_FIXED_CODE);
        sum      = {1'b0, lat} + {1'b0, lon};
        raw_conv = (sum <= {thr_mm, 1'b0});
        if (!seeded) begin
            // first item after reset takes the raw flags as they are
            seeded            = 1'b1;
            rtk_deb.stable    = raw_rtk;
            rtk_deb.pend_cnt  = '0;
            conv_deb.stable   = raw_conv;
            conv_deb.pend_cnt = '0;
            e.rtk_chg         = 1'b0;
            e.conv_chg        = 1'b0;
        end
        else begin
            nr         = qualify(rtk_deb, raw_rtk, confirm);
            nc         = qualify(conv_deb, raw_conv, confirm);
            e.rtk_chg  = (nr.stable != rtk_deb.stable);
            e.conv_chg = (nc.stable != conv_deb.stable);
            rtk_deb    = nr;
            conv_deb   = nc;
        end
        e.rtk  = rtk_deb.stable;
        e.conv = conv_deb.stable;
        status_q.push_back(e);
    endtask

    task automatic check_status();
        fix_status_t e;
        if (status_q.size() == 0) begin
            note_error("result with no item pending");
        end
        else begin
            e = status_q.pop_front();
            if (res.rtk_fixed_stable !== e.rtk)
                note_error($sformatf("rtk_fixed_stable got %b want %b",
                                     res.rtk_fixed_stable, e.rtk));
            if (res.std_converged_stable !== e.conv)
                note_error($sformatf("std_converged_stable got %b want %b",
                                     res.std_converged_stable, e.conv));
            if (res.rtk_changed !== e.rtk_chg)
                note_error($sformatf("rtk_changed got %b want %b",
                                     res.rtk_changed, e.rtk_chg));
            if (res.std_changed !== e.conv_chg)
                note_error($sformatf("std_changed got %b want %b",
                                     res.std_changed, e.conv_chg));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr_mm   = STD_THRESHOLD_RESET;
            confirm  = CONFIRM_RESET;
            seeded   = 1'b0;
            rtk_deb  = '0;
            conv_deb = '0;
            status_q.delete();
            outstanding <= 0;
        end
        else begin
            if (res.valid && res.ready)
                check_status();
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_STD_THRESHOLD)
                    thr_mm = cfg.data;
                else if (cfg.index == REG_CONFIRM)
                    confirm = cfg.data[CNT_W-1:0];
            end
            if (sol.valid && sol.ready)
                predict_status(sol.pos_type, sol.lat_std_mm, sol.lon_std_mm);
            outstanding <= status_q.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import gfsh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SUM_MAX     = 131070;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int outstanding;
    int fail_count;
    int snd_idle = 14;
    int rcv_idle = 68;
    int cycles   = 0;

    logic [STD_W-1:0] cur_thr  = STD_THRESHOLD_RESET;
    logic [CNT_W-1:0] cur_conf = CONFIRM_RESET;

    gfsh_sol_if sol();
    gfsh_res_if res();
    gfsh_cfg_if cfg();

    gnss_fix_status_hysteresis_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .sol   (sol),
        .res   (res),
        .cfg   (cfg)
    );

    fix_status_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sol         (sol),
        .res         (res),
        .cfg         (cfg),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            res.ready <= ($urandom_range(99) >= rcv_idle);
    end

    task automatic send_item(input logic [TYPE_W-1:0] ptype, input logic [STD_W-1:0] lat,
                             input logic [STD_W-1:0] lon);
        while ($urandom_range(99) < snd_idle)
        begin
            sol.valid <= 1'b0;
            @(posedge clk);
        end
        sol.valid      <= 1'b1;
        sol.pos_type   <= ptype;
        sol.lat_std_mm <= lat;
        sol.lon_std_mm <= lon;
        do @(posedge clk); while (!sol.ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        sol.valid <= 1'b0;
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_STD_THRESHOLD)
            cur_thr = val;
        else if (idx == REG_CONFIRM)
            cur_conf = val[CNT_W-1:0];
    endtask

    // confirm write with junk in the unused upper byte
    task automatic write_confirm(input logic [CNT_W-1:0] n);
        logic [CFG_DATA_W-1:0] val;
        val = {8'($urandom_range(255)), n};
        write_reg(REG_CONFIRM, val);
    endtask

    // item whose raw flags come out as asked, sum near the threshold now and then
    task automatic send_shaped(input logic want_rtk, input logic want_conv);
        logic [TYPE_W-1:0] pt;
        int lim;
        int s;
        int lo;
        int hi;
        int lat;
        int lon;
        pt = want_rtk ? RTK_FIXED_CODE : 8'($urandom_range(255));
        if (!want_rtk && pt == RTK_FIXED_CODE)
            pt = pt + 1'b1;
        lim = 2 * int'(cur_thr);
        if (want_conv)
            s = ($urandom_range(9) == 0) ? lim : $urandom_range(lim, 0);
        else if (lim >= SUM_MAX)
            s = $urandom_range(SUM_MAX, 0);
        else
            s = ($urandom_range(9) == 0) ? lim + 1 : $urandom_range(SUM_MAX, lim + 1);
        lo  = (s > 65535) ? s - 65535 : 0;
        hi  = (s < 65535) ? s : 65535;
        lat = $urandom_range(hi, lo);
        lon = s - lat;
        send_item(pt, lat[STD_W-1:0], lon[STD_W-1:0]);
    endtask

    // runs of steady raw flags so the debouncers get to flip, plus some noise
    task automatic run_random(input int n);
        int done;
        int len;
        int cap;
        int k;
        logic want_rtk;
        logic want_conv;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(8'($urandom_range(255)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)));
                done++;
            end
            else
            begin
                want_rtk  = 1'($urandom_range(1));
                want_conv = 1'($urandom_range(1));
                cap = (cur_conf > 10) ? 10 : int'(cur_conf);
                len = $urandom_range(cap + 2, 1);
                for (k = 0; k < len && done < n; k++)
                begin
                    send_shaped(want_rtk, want_conv);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        sol.valid      = 1'b0;
        sol.pos_type   = '0;
        sol.lat_std_mm = '0;
        sol.lon_std_mm = '0;
        res.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = '0;
        cfg.data       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // seeding item, then extremes and the threshold boundary
        send_item(RTK_FIXED_CODE, 16'd0, 16'd0);
        send_item(8'd0, 16'hFFFF, 16'hFFFF);
        send_item(8'd255, 16'd150, 16'd50);
        send_item(8'd3, 16'd100, 16'd101);
        send_item(RTK_FIXED_CODE, 16'd0, 16'd0);
        // five differing items in a row flip both flags
        send_item(8'd5, 16'd201, 16'd0);
        send_item(8'd8, 16'd0, 16'd201);
        send_item(8'd16, 16'd1000, 16'd1000);
        send_item(8'd128, 16'h8000, 16'h8000);
        send_item(8'd64, 16'hFFFF, 16'd0);
        // confirm of zero flips on the first differing item
        write_reg(REG_CONFIRM, 16'h0000);
        send_item(RTK_FIXED_CODE, 16'd50, 16'd50);
        write_reg(REG_STD_THRESHOLD, 16'h0000);
        send_item(RTK_FIXED_CODE, 16'd0, 16'd0);
        send_item(RTK_FIXED_CODE, 16'd0, 16'd1);
        write_reg(REG_STD_THRESHOLD, 16'hFFFF);
        send_item(8'd0, 16'hFFFF, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(8'd4, 16'd7, 16'd9);
        write_reg(REG_CONFIRM, 16'hFF02);
        send_item(8'd1, 16'd0, 16'hFFFF);
        send_item(8'd2, 16'h5555, 16'hAAAA);

        write_reg(REG_STD_THRESHOLD, 16'($urandom_range(400)));
        write_confirm(8'd3);
        run_random(180);
        write_reg(REG_STD_THRESHOLD, 16'($urandom_range(65535)));
        write_confirm(8'd1);
        run_random(180);

        snd_idle = 68;
        rcv_idle = 14;
        write_reg(REG_STD_THRESHOLD, 16'h0000);
        write_confirm(8'd2);
        run_random(180);
        write_reg(REG_STD_THRESHOLD, 16'($urandom_range(40000, 1000)));
        write_confirm(8'($urandom_range(9, 4)));
        run_random(180);

        snd_idle = 0;
        rcv_idle = 0;
        // longest confirm: the 255th differing item flips
        write_reg(REG_STD_THRESHOLD, 16'd100);
        write_confirm(8'd1);
        send_shaped(1'b1, 1'b1);
        write_confirm(8'd255);
        repeat (255) send_shaped(1'b0, 1'b1);
        // lower the confirm count while a run is pending
        repeat (120) send_shaped(1'b1, 1'b1);
        write_confirm(8'd40);
        send_shaped(1'b1, 1'b1);

        write_reg(REG_STD_THRESHOLD, 16'($urandom_range(65535)));
        write_confirm(8'd6);
        run_random(180);
        write_reg(REG_STD_THRESHOLD, 16'd50);
        write_confirm(8'd0);
        run_random(180);

        sol.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
